FILE: design/ipow_pkg.sv
// ----------------------------------------------------------------------------
// ipow_pkg
// Shared types for the square-and-multiply power pipeline.
// ----------------------------------------------------------------------------
package ipow_pkg;

   // Per-cycle control handed from the top level to every pipeline step.
   typedef struct packed {
      logic advance;   // whole pipe moves one step this cycle
      logic valid;     // the item entering this step is real
   } step_ctl_type;

endpackage

FILE: design/ipow_step.sv
// ----------------------------------------------------------------------------
// ipow_step
// One exponent bit of square-and-multiply: conditional multiply into the
// accumulator, squaring of the running base, exponent shifted down one bit.
// ----------------------------------------------------------------------------
module ipow_step #(
   parameter int DATA_WIDTH = 32,
   parameter int EXP_WIDTH  = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ipow_pkg::step_ctl_type    ctl,
   input  logic [DATA_WIDTH-1:0]     acc_i,
   input  logic [DATA_WIDTH-1:0]     sq_i,
   input  logic [EXP_WIDTH-1:0]      exp_i,
   output logic                      valid_o,
   output logic [DATA_WIDTH-1:0]     acc_o,
   output logic [DATA_WIDTH-1:0]     sq_o,
   output logic [EXP_WIDTH-1:0]      exp_o
);
   import ipow_pkg::*;

   logic                  valid_ff;
   logic [DATA_WIDTH-1:0] acc_ff, acc_in;
   logic [DATA_WIDTH-1:0] sq_ff, sq_in;
   logic [EXP_WIDTH-1:0]  exp_ff, exp_in;
   logic [DATA_WIDTH-1:0] mul_acc;
   logic [DATA_WIDTH-1:0] mul_sq;

   // Products keep only the low DATA_WIDTH bits (wrap-around).
   assign mul_acc = acc_i * sq_i;
   assign mul_sq  = sq_i * sq_i;

   always_comb begin
      acc_in = exp_i[0] ? mul_acc : acc_i;
      sq_in  = mul_sq;
      exp_in = exp_i >> 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.advance) begin
         valid_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         acc_ff <= acc_in;
         sq_ff  <= sq_in;
         exp_ff <= exp_in;
      end
   end

   assign valid_o = valid_ff;
   assign acc_o   = acc_ff;
   assign sq_o    = sq_ff;
   assign exp_o   = exp_ff;

endmodule

FILE: design/integer_power_by_squaring_core.sv
// ----------------------------------------------------------------------------
// integer_power_by_squaring_core
// base ** exponent modulo 2^DATA_WIDTH, one pipeline step per exponent bit.
//
//   channel | dir | tdata (low bit up)              | beat
//   req     | in  | base, exponent, zero pad        | one operand pair
//   rsp     | out | power, zero pad                 | one result
//
// A req beat passes through every step register to rsp valid; a new beat
// can enter every cycle unless frozen. Each step holds one multiply into the
// accumulator and one squaring, both registered at the step's end.
// Reset clears only the valid bits. The last step is the output register;
// when it holds an untaken beat the whole pipe freezes and req_tready drops.
// ----------------------------------------------------------------------------
module integer_power_by_squaring_core #(
   parameter int DATA_WIDTH = 32,
   parameter int EXP_WIDTH  = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic                                        req_tvalid,
   output logic                                        req_tready,
   // base [DATA_WIDTH-1:0], exponent [+EXP_WIDTH], zero pad
   input  logic [((DATA_WIDTH+EXP_WIDTH+7)/8)*8-1:0]   req_tdata,
   output logic                                        rsp_tvalid,
   input  logic                                        rsp_tready,
   // power [DATA_WIDTH-1:0], zero pad
   output logic [((DATA_WIDTH+7)/8)*8-1:0]             rsp_tdata
);
   import ipow_pkg::*;

   localparam int RSP_W = ((DATA_WIDTH + 7) / 8) * 8;

   logic                  advance;
   logic [EXP_WIDTH:0]    valid_c;
   logic [DATA_WIDTH-1:0] acc_c [EXP_WIDTH+1];
   logic [DATA_WIDTH-1:0] sq_c  [EXP_WIDTH+1];
   logic [EXP_WIDTH-1:0]  exp_c [EXP_WIDTH+1];

   assign advance    = !valid_c[EXP_WIDTH] || rsp_tready;
   assign req_tready = advance;

   assign valid_c[0] = req_tvalid;
   assign acc_c[0]   = DATA_WIDTH'(1);
   assign sq_c[0]    = req_tdata[DATA_WIDTH-1:0];
   assign exp_c[0]   = req_tdata[DATA_WIDTH +: EXP_WIDTH];

   for (genvar g = 0; g < EXP_WIDTH; g++) begin : g_step
      step_ctl_type ctl;
      assign ctl.advance = advance;
      assign ctl.valid   = valid_c[g];

      ipow_step #(
         .DATA_WIDTH (DATA_WIDTH),
         .EXP_WIDTH  (EXP_WIDTH)
      ) u_step (
         .clock   (clock),
         .reset   (reset),
         .ctl     (ctl),
         .acc_i   (acc_c[g]),
         .sq_i    (sq_c[g]),
         .exp_i   (exp_c[g]),
         .valid_o (valid_c[g+1]),
         .acc_o   (acc_c[g+1]),
         .sq_o    (sq_c[g+1]),
         .exp_o   (exp_c[g+1])
      );
   end

   assign rsp_tvalid = valid_c[EXP_WIDTH];
   assign rsp_tdata  = RSP_W'(acc_c[EXP_WIDTH]);

endmodule
